@@ hdl/sss_pkg.sv @@
// shared types, constants and functions for the short string selection sort core
// no dependencies
package sss_pkg;

  localparam int TEXT_W            = 64;
  localparam int BYTE_COUNT        = TEXT_W / 8;
  localparam int MAX_CHARS         = 8;
  localparam int ENTRY_COUNT_DEF   = 8;

  typedef struct packed {
    logic load_ready;
    logic read;
    logic emit;
  } sss_cmd_t;

  typedef struct packed {
    logic load_end;
    logic scan_last;
    logic pass_last;
    logic out_free;
  } sss_status_t;

  function automatic logic [TEXT_W-1:0] normalize_text(input logic [TEXT_W-1:0] t);
    logic [TEXT_W-1:0] r;
    logic              ended;
    logic [7:0]        b;
    r     = '0;
    ended = 1'b0;
    for (int i = 0; i < BYTE_COUNT; i++) begin
      b = t[(BYTE_COUNT-1-i)*8 +: 8];
      if (i >= MAX_CHARS || b == 8'd0) begin
        ended = 1'b1;
      end
      if (!ended) begin
        r[(BYTE_COUNT-1-i)*8 +: 8] = b;
      end
    end
    return r;
  endfunction

endpackage

@@ hdl/sss_datapath.sv @@
// string store, minimum search and output register of the sort core
// depends on sss_pkg
module sss_datapath #(
  parameter int ENTRY_COUNT = sss_pkg::ENTRY_COUNT_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [sss_pkg::TEXT_W-1:0] text,
  input  logic                     is_last,
  input  logic                     in_valid,
  output logic                     in_stall,
  output logic [sss_pkg::TEXT_W-1:0] sorted_text,
  output logic                     final_flag,
  output logic                     out_valid,
  input  logic                     out_stall,
  input  sss_pkg::sss_cmd_t        cmd,
  output sss_pkg::sss_status_t     status
);
  import sss_pkg::*;

  localparam int IDX_W = $clog2(ENTRY_COUNT);
  localparam int CNT_W = $clog2(ENTRY_COUNT + 1);
  localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(ENTRY_COUNT - 1);

  logic [TEXT_W-1:0] store [ENTRY_COUNT];
  logic [TEXT_W-1:0] rd_data;
  logic              rd_valid;
  logic [CNT_W-1:0]  rd_idx;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  i;
  logic [CNT_W-1:0]  j;
  logic [TEXT_W-1:0] best;
  logic [CNT_W-1:0]  best_idx;
  logic [TEXT_W-1:0] first_val;
  logic              accept;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [TEXT_W-1:0] wr_data;

  assign in_stall = !cmd.load_ready;
  assign accept   = in_valid && cmd.load_ready;

  // closing request offered; taken whenever the controller is loading
  assign status.load_end  = in_valid && (is_last || count == LAST_SLOT);
  assign status.scan_last = (j + CNT_W'(1)) == count;
  assign status.pass_last = (i + CNT_W'(1)) == count;
  assign status.out_free  = !out_valid || !out_stall;

  assign wr_en   = accept || cmd.emit;
  assign wr_addr = accept ? count[IDX_W-1:0] : best_idx[IDX_W-1:0];
  assign wr_data = accept ? normalize_text(text) : first_val;

  // store memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    if (cmd.read) begin
      rd_data <= store[j[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      i         <= '0;
      j         <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.read;
      if (cmd.read) begin
        rd_idx <= j;
        j      <= j + CNT_W'(1);
      end
      if (accept) begin
        count <= count + CNT_W'(1);
        i     <= '0;
        j     <= '0;
      end
      // minimum search over the scanned entries
      if (rd_valid) begin
        if (rd_idx == i) begin
          best      <= rd_data;
          best_idx  <= rd_idx;
          first_val <= rd_data;
        end else if (rd_data < best) begin
          best     <= rd_data;
          best_idx <= rd_idx;
        end
      end
      if (cmd.emit) begin
        sorted_text <= best;
        final_flag  <= status.pass_last;
        out_valid   <= 1'b1;
        i           <= i + CNT_W'(1);
        j           <= i + CNT_W'(1);
        if (status.pass_last) begin
          count <= '0;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(ENTRY_COUNT))
    else $error("store count out of range");

  a_read_in_set: assert property (@(posedge clk) disable iff (rst)
    cmd.read |-> j < count)
    else $error("read beyond stored strings");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(out_valid && out_stall))
    else $error("result overwritten while stalled");

  a_no_load_in_sort: assert property (@(posedge clk) disable iff (rst)
    cmd.read |-> !accept)
    else $error("request taken during sort");

endmodule

@@ hdl/sss_ctrl.sv @@
// controller state machine sequencing load, scan passes and result emission
// depends on sss_pkg
module sss_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  sss_pkg::sss_status_t status,
  output sss_pkg::sss_cmd_t    cmd
);
  import sss_pkg::*;

  typedef enum logic [1:0] {
    LOAD,
    SCAN,
    DRAIN,
    EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      LOAD: begin
        cmd.load_ready = 1'b1;
        if (status.load_end) begin
          state_next = SCAN;
        end
      end
      SCAN: begin
        cmd.read = 1'b1;
        if (status.scan_last) begin
          state_next = DRAIN;
        end
      end
      DRAIN: begin
        state_next = EMIT;
      end
      EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = status.pass_last ? LOAD : SCAN;
        end
      end
      default: begin
        state_next = LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LOAD;
    end else begin
      state <= state_next;
    end
  end

  a_drain_then_emit: assert property (@(posedge clk) disable iff (rst)
    state == DRAIN |=> state == EMIT)
    else $error("drain not followed by emit");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_ready, cmd.read, cmd.emit}))
    else $error("conflicting commands");

  a_scan_from_load: assert property (@(posedge clk) disable iff (rst)
    (state == LOAD && status.load_end) |=> state == SCAN)
    else $error("sort did not start");

endmodule

@@ hdl/short_string_selection_sort_core.sv @@
// short string selection sort core: top level joining controller and datapath
// depends on sss_pkg, sss_ctrl, sss_datapath
//
// usage: strings come in one request per cycle on text/is_last with in_valid
// while in_stall is low, packed first char in the top byte and zero padded.
// bytes after the first zero byte are cleared. a request with is_last set, or
// the one that fills the store of ENTRY_COUNT entries, closes the set. the core
// then stalls input, sorts ascending and sends every stored string on
// sorted_text with out_valid, final_flag set on the last one, after which input
// opens again. a set of n strings is sorted in n passes, each a scan state with
// one store read per cycle through the single memory read port, a drain state
// and an emit state. the first result leaves from the emit state of the first
// pass, after its scan and drain states.
// out_stall holds the result register, and the sort waits at each emit until
// the register is free. reset returns to loading with an empty store; no
// clearing pass is needed.
module short_string_selection_sort_core #(
  parameter int ENTRY_COUNT = sss_pkg::ENTRY_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [sss_pkg::TEXT_W-1:0] text,
  input  logic                       is_last,
  input  logic                       in_valid,
  output logic                       in_stall,
  output logic [sss_pkg::TEXT_W-1:0] sorted_text,
  output logic                       final_flag,
  output logic                       out_valid,
  input  logic                       out_stall
);
  import sss_pkg::*;

  sss_cmd_t    cmd;
  sss_status_t status;

  sss_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  sss_datapath #(
    .ENTRY_COUNT (ENTRY_COUNT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .text        (text),
    .is_last     (is_last),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sorted_text (sorted_text),
    .final_flag  (final_flag),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cmd         (cmd),
    .status      (status)
  );

endmodule

@@ sim/sort_order_checker.sv @@
// checker for the short string selection sort core: watches both channels,
// predicts the sorted output of every closed set and compares it field by field
// depends on sss_pkg for the string width, character limit and set size
`timescale 1ns / 1ps

module sort_order_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [sss_pkg::TEXT_W-1:0] text,
  input  logic                       is_last,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [sss_pkg::TEXT_W-1:0] sorted_text,
  input  logic                       final_flag,
  input  logic                       out_valid,
  input  logic                       out_stall,
  output int                         mismatches,
  output int                         outstanding
);

  localparam int SET_LIMIT = sss_pkg::ENTRY_COUNT_DEF;

  typedef struct packed {
    logic [sss_pkg::TEXT_W-1:0] word;
    logic                       closes;
  } sorted_entry_t;

  logic [sss_pkg::TEXT_W-1:0] open_set[$];
  sorted_entry_t              awaited_sorted[$];

  // keep the top bytes up to the first zero byte or the character limit
  function automatic logic [sss_pkg::TEXT_W-1:0] clip_string(
    input logic [sss_pkg::TEXT_W-1:0] raw
  );
    logic [sss_pkg::TEXT_W-1:0] keep;
    logic                       alive;
    keep  = '0;
    alive = 1'b1;
    for (int k = sss_pkg::BYTE_COUNT - 1; k >= 0; k--) begin
      if (raw[8*k +: 8] == 8'h00 || (sss_pkg::BYTE_COUNT - 1 - k) >= sss_pkg::MAX_CHARS) begin
        alive = 1'b0;
      end
      if (alive) begin
        keep[8*k +: 8] = raw[8*k +: 8];
      end
    end
    return keep;
  endfunction

  // order the open set ascending and queue it as the expected output
  task automatic release_set();
    int                         pick;
    logic [sss_pkg::TEXT_W-1:0] held;
    for (int i = 0; i < open_set.size(); i++) begin
      pick = i;
      for (int j = i + 1; j < open_set.size(); j++) begin
        if (open_set[j] < open_set[pick]) begin
          pick = j;
        end
      end
      held           = open_set[i];
      open_set[i]    = open_set[pick];
      open_set[pick] = held;
      awaited_sorted.push_back('{word: open_set[i], closes: (i == open_set.size() - 1)});
    end
    open_set.delete();
  endtask

  task automatic flag_mismatch(input sorted_entry_t want, input logic have_want);
    mismatches++;
    if (mismatches <= 10) begin
      if (have_want) begin
        $display("mismatch at %0t: expected text %h final %b, got text %h final %b",
                 $realtime, want.word, want.closes, sorted_text, final_flag);
      end else begin
        $display("mismatch at %0t: unexpected result text %h final %b",
                 $realtime, sorted_text, final_flag);
      end
    end
  endtask

  always @(posedge clk) begin
    sorted_entry_t want;
    if (rst) begin
      mismatches  = 0;
      outstanding = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_sorted.size() == 0) begin
          want = '0;
          flag_mismatch(want, 1'b0);
        end else begin
          want = awaited_sorted.pop_front();
          if (want.word !== sorted_text || want.closes !== final_flag) begin
            flag_mismatch(want, 1'b1);
          end
        end
      end
      if (in_valid && !in_stall) begin
        open_set.push_back(clip_string(text));
        if (is_last || open_set.size() >= SET_LIMIT) begin
          release_set();
        end
      end
      outstanding = awaited_sorted.size();
    end
  end

endmodule

@@ sim/testbench.sv @@
// top of the short string selection sort testbench: clock, reset, string
// requests, result stalls and the verdict
// depends on sss_pkg, short_string_selection_sort_core and sort_order_checker
`timescale 1ns / 1ps

module testbench;

  localparam int ITEM_TARGET = 350;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SET_LIMIT   = sss_pkg::ENTRY_COUNT_DEF;

  logic                       clk;
  logic                       rst;
  logic [sss_pkg::TEXT_W-1:0] text;
  logic                       is_last;
  logic                       in_valid;
  logic                       in_stall;
  logic [sss_pkg::TEXT_W-1:0] sorted_text;
  logic                       final_flag;
  logic                       out_valid;
  logic                       out_stall;

  int                         mismatches;
  int                         outstanding;
  int                         cycle_count = 0;
  int                         strings_sent;
  int                         results_taken;
  logic                       sender_quiet;
  logic                       receiver_quiet;
  logic [sss_pkg::TEXT_W-1:0] prior_text;

  short_string_selection_sort_core DUT (
    .clk        (clk),
    .rst        (rst),
    .text       (text),
    .is_last    (is_last),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sorted_text(sorted_text),
    .final_flag (final_flag),
    .out_valid  (out_valid),
    .out_stall  (out_stall)
  );

  sort_order_checker checker_inst (
    .clk        (clk),
    .rst        (rst),
    .text       (text),
    .is_last    (is_last),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sorted_text(sorted_text),
    .final_flag (final_flag),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // one string request, called at a falling edge, returns at a falling edge
  task automatic send_string(input logic [sss_pkg::TEXT_W-1:0] word, input logic closes);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    text     <= word;
    is_last  <= closes;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    strings_sent++;
    prior_text = word;
    @(negedge clk);
  endtask

  function automatic logic [sss_pkg::TEXT_W-1:0] random_string();
    logic [sss_pkg::TEXT_W-1:0] word;
    int                         len;
    word = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0, 1: begin
        // printable string with junk after the terminator
        len = $urandom_range(0, sss_pkg::BYTE_COUNT);
        for (int k = 0; k < len; k++) begin
          word[(sss_pkg::BYTE_COUNT-1-k)*8 +: 8] = 8'($urandom_range(8'h20, 8'h7e));
        end
        if (len < sss_pkg::BYTE_COUNT) begin
          word[(sss_pkg::BYTE_COUNT-1-len)*8 +: 8] = 8'h00;
        end
      end
      2, 3: begin
        // tiny alphabet so prefixes and duplicates are common
        word = '0;
        len  = $urandom_range(0, 4);
        for (int k = 0; k < len; k++) begin
          word[(sss_pkg::BYTE_COUNT-1-k)*8 +: 8] = 8'($urandom_range(8'h61, 8'h63));
        end
      end
      4: word = prior_text;
      default: ;
    endcase
    return word;
  endfunction

  // result side: a random hold before each result unless the receiver is quiet, one long hold-off
  initial begin
    int hold;
    out_stall      = 1'b1;
    receiver_quiet = 1'b0;
    results_taken  = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      hold = receiver_quiet ? 0 : $urandom_range(0, 15);
      if (results_taken == 30) begin
        hold = 400;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      results_taken++;
      if (results_taken % 40 == 0) begin
        receiver_quiet = ($urandom_range(0, 2) == 0);
      end
      @(negedge clk);
    end
  end

  initial begin
    int set_size;
    logic shut_by_flag;
    rst          = 1'b1;
    text         = '0;
    is_last      = 1'b0;
    in_valid     = 1'b0;
    strings_sent = 0;
    sender_quiet = 1'b0;
    prior_text   = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // single strings: empty and all ones
    send_string(64'h0000_0000_0000_0000, 1'b1);
    send_string(64'hffff_ffff_ffff_ffff, 1'b1);
    // junk after the terminator, equal after clipping
    send_string(64'h4200_1234_5678_9abc, 1'b0);
    send_string(64'h4100_0000_0000_0000, 1'b0);
    send_string(64'h4200_0000_0000_0000, 1'b1);
    // full store with no closing flag
    send_string(64'h8000_0000_0000_0000, 1'b0);
    send_string(64'h7fff_ffff_ffff_ffff, 1'b0);
    send_string(64'h0000_0000_0000_0001, 1'b0);
    send_string(64'hffff_ffff_ffff_fffe, 1'b0);
    send_string(64'h0100_0000_0000_0000, 1'b0);
    send_string(64'h6162_6300_6465_6600, 1'b0);
    send_string(64'h6162_6364_6566_6768, 1'b0);
    send_string(64'h6162_6364_6566_6767, 1'b0);
    // shared prefix, descending
    send_string(64'h4142_4344_4546_4748, 1'b0);
    send_string(64'h4142_4344_4546_4741, 1'b1);
    // full store with the closing flag on the filling string
    sender_quiet = 1'b1;
    for (int k = 0; k < SET_LIMIT; k++) begin
      send_string(64'h5a00_0000_0000_0000 - 64'(k) * 64'h0100_0000_0000_0000,
                  k == SET_LIMIT - 1);
    end

    while (strings_sent < ITEM_TARGET) begin
      sender_quiet = ($urandom_range(0, 3) == 0);
      shut_by_flag = ($urandom_range(0, 4) != 0);
      set_size     = shut_by_flag ? $urandom_range(1, SET_LIMIT) : SET_LIMIT;
      for (int k = 0; k < set_size; k++) begin
        send_string(random_string(), shut_by_flag && (k == set_size - 1));
      end
    end
    in_valid <= 1'b0;
    is_last  <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
